### design/fmsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmsv_pkg
// Shared constants, types and the sine table builder of the FM voice engine.
// ----------------------------------------------------------------------------
package fmsv_pkg;

  localparam int VOICES         = 16;
  localparam int SINE_ADDR_BITS = 10;
  localparam int VIDX_W         = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VOICE_W        = 4;
  localparam int ROM_AW         = SINE_ADDR_BITS + 1;
  localparam int ROM_DEPTH      = (1 << SINE_ADDR_BITS) + 1;
  localparam int SUM_W          = 21 + VIDX_W;
  localparam int MASK_W         = 16;
  localparam int SAMPLE_W       = 24;

  localparam logic [15:0] ENV_ONE   = 16'd32768;
  localparam logic [15:0] ENV_FLOOR = 16'd66;
  localparam logic [14:0] MIX_GAIN  = 15'd22938;
  localparam logic [15:0] RECIP_127 = 16'd33026;
  localparam logic [6:0]  DIV_127   = 7'd127;

  // Input operation codes.
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_NOTE_OFF = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_MOD_RATIO   = 3'd0;
  localparam logic [2:0] REG_MOD_INDEX   = 3'd1;
  localparam logic [2:0] REG_ATTACK_COEF = 3'd2;
  localparam logic [2:0] REG_DECAY_COEF  = 3'd3;
  localparam logic [2:0] REG_START_LEVEL = 3'd4;

  // Datapath commands.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_NOTE_ON  = 4'd1;
  localparam logic [3:0] CMD_NOTE_OFF = 4'd2;
  localparam logic [3:0] CMD_START    = 4'd3;
  localparam logic [3:0] CMD_ENV      = 4'd4;
  localparam logic [3:0] CMD_MUL1     = 4'd5;
  localparam logic [3:0] CMD_MUL2     = 4'd6;
  localparam logic [3:0] CMD_TMUL     = 4'd7;
  localparam logic [3:0] CMD_VMUL     = 4'd8;
  localparam logic [3:0] CMD_RECIP    = 4'd9;
  localparam logic [3:0] CMD_ACC      = 4'd10;
  localparam logic [3:0] CMD_MIX1     = 4'd11;
  localparam logic [3:0] CMD_MIX2     = 4'd12;

  typedef struct packed {
    logic [3:0]        code;
    logic [VIDX_W-1:0] voice;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic died;
  } status_t;

  typedef struct packed {
    logic [15:0] mod_ratio;
    logic [15:0] mod_index;
    logic [15:0] attack_coef;
    logic [15:0] decay_coef;
    logic [15:0] start_level;
  } cfg_t;

  typedef logic [14:0] sine_rom_t [0:ROM_DEPTH-1];

  // Quarter-wave table built with a Q30 Taylor series up to u^9.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] q;
    for (int x = 0; x < ROM_DEPTH; x++) begin
      u  = (64'(x) * 64'd1686629713) >> SINE_ADDR_BITS;
      u2 = (u * u) >> 30;
      r  = (64'd1 << 30) - u2 / 64'd72;
      r  = (64'd1 << 30) - ((u2 * r) >> 30) / 64'd42;
      r  = (64'd1 << 30) - ((u2 * r) >> 30) / 64'd20;
      r  = (64'd1 << 30) - ((u2 * r) >> 30) / 64'd6;
      s  = (u * r) >> 30;
      q  = (s + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[x] = q[14:0];
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

### design/fm_synth_voice_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fm_synth_voice_engine_unit
// Sixteen-voice two-operator FM synthesizer with an APB register port.
// ----------------------------------------------------------------------------
// Note-on and note-off requests update the voice state and produce no result.
// A tick request clears the sum, updates the envelope of each active voice and
// runs the shared multiply chain for each sounding one, skipping idle or expiring
// voices; the sequencer steps through one voice at a time, then mixes the sum.
// The next request is taken once the tick's result sits in the output register.
// Reset is asynchronous and active low; all voices come out idle, registers at
// their default values, and no clearing pass is needed.
module fm_synth_voice_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request stream. tdata: op[1:0], voice[5:2], carrier step[37:6],
  // velocity[44:38], zero fill [47:45].
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [47:0] s_tdata_i,
  // Result stream. tdata: sample[23:0], active_mask[39:24].
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [39:0]      m_tdata_o,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fmsv_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  logic [VOICES-1:0]   active;
  logic [SAMPLE_W-1:0] sample;
  logic [MASK_W-1:0]   mask;
  logic [VOICES+MASK_W-1:0] active_ext;
  logic                out_load, out_free;
  logic                m_valid_q;
  logic [39:0]         m_data_q;
  logic [2:0]          reg_idx;
  logic                wr_en;

  // Configuration registers: a write lands in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mod_ratio   <= 16'd8192;
      cfg_q.mod_index   <= 16'd1956;
      cfg_q.attack_coef <= 16'd64797;
      cfg_q.decay_coef  <= 16'd65531;
      cfg_q.start_level <= 16'd32768;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MOD_RATIO:   cfg_q.mod_ratio   <= pwdata[15:0];
        REG_MOD_INDEX:   cfg_q.mod_index   <= pwdata[15:0];
        REG_ATTACK_COEF: cfg_q.attack_coef <= pwdata[15:0];
        REG_DECAY_COEF:  cfg_q.decay_coef  <= pwdata[15:0];
        REG_START_LEVEL: cfg_q.start_level <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MOD_RATIO:   prdata = {16'd0, cfg_q.mod_ratio};
      REG_MOD_INDEX:   prdata = {16'd0, cfg_q.mod_index};
      REG_ATTACK_COEF: prdata = {16'd0, cfg_q.attack_coef};
      REG_DECAY_COEF:  prdata = {16'd0, cfg_q.decay_coef};
      REG_START_LEVEL: prdata = {16'd0, cfg_q.start_level};
      default:         prdata = '0;
    endcase
  end

  // The sequencer decodes requests and steps the datapath one voice at a time.
  fmsv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_op_i    (s_tdata_i[1:0]),
    .in_voice_i (s_tdata_i[5:2]),
    .in_ready_o (s_tready_o),
    .status_i   (status),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  fmsv_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .in_step_i     (s_tdata_i[37:6]),
    .in_velocity_i (s_tdata_i[44:38]),
    .status_o      (status),
    .active_o      (active),
    .sample_o      (sample)
  );

  // Only the first sixteen voices are visible in the mask.
  assign active_ext = (VOICES + MASK_W)'(active);
  assign mask       = active_ext[MASK_W-1:0];

  // Output register decouples the result from the next request.
  assign out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {mask, sample};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule
`default_nettype wire

### design/fmsv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmsv_ctrl
// Sequencer that walks the voices of one tick and steps the datapath.
// ----------------------------------------------------------------------------
module fmsv_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [1:0]                 in_op_i,
  input  wire logic [fmsv_pkg::VOICE_W-1:0] in_voice_i,
  output logic                            in_ready_o,
  input  wire fmsv_pkg::status_t          status_i,
  input  wire logic                       out_free_i,
  output logic                            out_load_o,
  output fmsv_pkg::cmd_t                  cmd_o
);
  import fmsv_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ENV   = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_TMUL  = 4'd4;
  localparam logic [3:0] ST_VMUL  = 4'd5;
  localparam logic [3:0] ST_RECIP = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_MIX1  = 4'd8;
  localparam logic [3:0] ST_MIX2  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);

  logic [3:0]              state_q, state_d;
  logic [VIDX_W-1:0]       vidx_q, vidx_d;
  logic [VIDX_W+VOICE_W-1:0] vext;
  logic                    in_acc;
  logic                    vok;

  assign vext       = (VIDX_W + VOICE_W)'(in_voice_i);
  assign vok        = vext < (VIDX_W + VOICE_W)'(VOICES);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    vidx_d     = vidx_q;
    cmd_o.code = CMD_NONE;
    cmd_o.voice = vidx_q;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.voice = vext[VIDX_W-1:0];
        if (in_acc) begin
          priority if (in_op_i == OP_TICK) begin
            cmd_o.code = CMD_START;
            vidx_d     = '0;
            state_d    = ST_ENV;
          end else if (in_op_i == OP_NOTE_ON && vok) begin
            cmd_o.code = CMD_NOTE_ON;
          end else if (in_op_i == OP_NOTE_OFF && vok) begin
            cmd_o.code = CMD_NOTE_OFF;
          end else begin
            cmd_o.code = CMD_NONE;
          end
        end
      end
      ST_ENV: begin
        if (status_i.active) begin
          cmd_o.code = CMD_ENV;
        end
        if (!status_i.active || status_i.died) begin
          if (vidx_q == LAST_VOICE) begin
            state_d = ST_MIX1;
          end else begin
            vidx_d = vidx_q + 1'b1;
          end
        end else begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.code = CMD_MUL1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.code = CMD_MUL2;
        state_d    = ST_TMUL;
      end
      ST_TMUL: begin
        cmd_o.code = CMD_TMUL;
        state_d    = ST_VMUL;
      end
      ST_VMUL: begin
        cmd_o.code = CMD_VMUL;
        state_d    = ST_RECIP;
      end
      ST_RECIP: begin
        cmd_o.code = CMD_RECIP;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.code = CMD_ACC;
        if (vidx_q == LAST_VOICE) begin
          state_d = ST_MIX1;
        end else begin
          vidx_d  = vidx_q + 1'b1;
          state_d = ST_ENV;
        end
      end
      ST_MIX1: begin
        cmd_o.code = CMD_MIX1;
        state_d    = ST_MIX2;
      end
      ST_MIX2: begin
        cmd_o.code = CMD_MIX2;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vidx_q  <= '0;
    end else begin
      state_q <= state_d;
      vidx_q  <= vidx_d;
    end
  end

`ifndef ASSERT_OFF
  a_tick_starts_at_voice0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OP_TICK |=> state_q == ST_ENV && vidx_q == '0)
    else $error("tick did not start at the first voice");
  a_mix_after_last_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MIX1 |-> $past(vidx_q) == LAST_VOICE)
    else $error("mix entered before the last voice");
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i && state_q == ST_OUT)
    else $error("result loaded into a full output register");
`endif

endmodule
`default_nettype wire

### design/fmsv_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fmsv_datapath
// Voice state, sine table and the shared arithmetic of the FM voice engine.
// ----------------------------------------------------------------------------
module fmsv_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fmsv_pkg::cmd_t               cmd_i,
  input  wire fmsv_pkg::cfg_t               cfg_i,
  input  wire logic [31:0]                  in_step_i,
  input  wire logic [6:0]                   in_velocity_i,
  output fmsv_pkg::status_t                 status_o,
  output logic [fmsv_pkg::VOICES-1:0]       active_o,
  output logic [fmsv_pkg::SAMPLE_W-1:0]     sample_o
);
  import fmsv_pkg::*;

  localparam sine_rom_t SineRom = build_sine_rom();

  logic [31:0] cphase_q [VOICES];
  logic [31:0] mphase_q [VOICES];
  logic [31:0] cstep_q  [VOICES];
  logic [31:0] mstep_q  [VOICES];
  logic [15:0] env_arr_q [VOICES];
  logic [6:0]  vel_q    [VOICES];
  logic [VOICES-1:0] active_q;
  logic [VOICES-1:0] rel_q;

  logic [VIDX_W-1:0] k;
  logic [15:0] env_cur, env_new, start_sat, att_gap;
  logic [31:0] rel_prod, att_prod;
  logic [47:0] modstep_prod;
  logic        releasing, died;

  logic [ROM_AW-1:0] rom_addr;
  logic [31:0]       rom_phase;
  logic [14:0]       rom_q;
  logic              sneg_q;

  logic [15:0] env_q;
  logic        mneg_q, cneg_q;
  logic [14:0] msmag_q;
  logic [31:0] mprod_q;
  logic [46:0] mmag;
  logic [31:0] off, arg;
  logic [30:0] tp_q;
  logic [37:0] tv_prod;
  logic [26:0] a_q;
  logic [42:0] rc_prod;
  logic [20:0] q0_q;
  logic [27:0] rem;
  logic [20:0] qv;
  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]  smag;
  logic [SUM_W+15:0] mix_prod;
  logic [SUM_W-1:0]  mix_q;
  logic              mixneg_q;
  logic signed [SUM_W:0] sval;
  logic [SAMPLE_W-1:0]   sample_q;

  assign k         = cmd_i.voice;
  assign env_cur   = env_arr_q[k];
  assign releasing = rel_q[k];
  assign rel_prod  = env_cur * cfg_i.decay_coef;
  assign att_gap   = ENV_ONE - env_cur;
  assign att_prod  = att_gap * cfg_i.attack_coef;
  assign start_sat = (cfg_i.start_level > ENV_ONE) ? ENV_ONE : cfg_i.start_level;
  assign modstep_prod = in_step_i * cfg_i.mod_ratio;

  always_comb begin
    if (releasing) begin
      env_new = rel_prod[31:16];
    end else if (env_cur < ENV_ONE) begin
      env_new = ENV_ONE - att_prod[31:16];
    end else begin
      env_new = env_cur;
    end
  end

  assign died = releasing && (env_new < ENV_FLOOR);
  assign status_o.active = active_q[k];
  assign status_o.died   = died;
  assign active_o        = active_q;

  // Phase offset from the modulator, Q.42 turns shifted down to Q.32.
  assign mmag = mprod_q * msmag_q;
  assign off  = mmag[41:10];
  assign arg  = mneg_q ? (cphase_q[k] - off) : (cphase_q[k] + off);

  // Sine lookup: quadrant from the top bits, mirrored on odd quadrants.
  assign rom_phase = (cmd_i.code == CMD_MUL2) ? arg : mphase_q[k];
  always_comb begin
    if (rom_phase[30]) begin
      rom_addr = ROM_AW'(1 << SINE_ADDR_BITS)
               - ROM_AW'(rom_phase[29 -: SINE_ADDR_BITS]);
    end else begin
      rom_addr = ROM_AW'(rom_phase[29 -: SINE_ADDR_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q  <= SineRom[rom_addr];
    sneg_q <= rom_phase[31];
  end

  // Division by 127 through a reciprocal with one correction step.
  assign tv_prod = tp_q * vel_q[k];
  assign rc_prod = a_q * RECIP_127;
  assign rem     = 28'(a_q) - 28'(q0_q) * 28'(DIV_127);
  assign qv      = (rem >= 28'(DIV_127)) ? q0_q + 1'b1 : q0_q;

  assign smag     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign mix_prod = smag * MIX_GAIN + (SUM_W+16)'(32768);
  assign sval     = mixneg_q ? -$signed({1'b0, mix_q}) : $signed({1'b0, mix_q});

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.code)
      CMD_ENV: begin
        env_q <= env_new;
      end
      CMD_MUL1: begin
        mprod_q <= cfg_i.mod_index * env_q;
        msmag_q <= rom_q;
        mneg_q  <= sneg_q;
      end
      CMD_TMUL: begin
        tp_q   <= rom_q * env_q;
        cneg_q <= sneg_q;
      end
      CMD_VMUL: begin
        a_q <= tv_prod[37:11];
      end
      CMD_RECIP: begin
        q0_q <= rc_prod[42:22];
      end
      CMD_MIX1: begin
        mix_q    <= mix_prod[SUM_W+15:16];
        mixneg_q <= sum_q[SUM_W-1];
      end
      CMD_MIX2: begin
        if (sval > $signed((SUM_W+1)'(8388607))) begin
          sample_q <= SAMPLE_W'(8388607);
        end else if (sval < -$signed((SUM_W+1)'(8388608))) begin
          sample_q <= SAMPLE_W'(8388608);
        end else begin
          sample_q <= sval[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign sample_o = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        cphase_q[v]  <= '0;
        mphase_q[v]  <= '0;
        cstep_q[v]   <= '0;
        mstep_q[v]   <= '0;
        env_arr_q[v] <= '0;
        vel_q[v]     <= '0;
      end
      active_q <= '0;
      rel_q    <= '0;
      sum_q    <= '0;
    end else begin
      unique case (cmd_i.code)
        CMD_NOTE_ON: begin
          cstep_q[k]   <= in_step_i;
          mstep_q[k]   <= modstep_prod[43:12];
          cphase_q[k]  <= '0;
          mphase_q[k]  <= '0;
          env_arr_q[k] <= start_sat;
          vel_q[k]     <= in_velocity_i;
          active_q[k]  <= 1'b1;
          rel_q[k]     <= 1'b0;
        end
        CMD_NOTE_OFF: begin
          rel_q[k] <= 1'b1;
        end
        CMD_START: begin
          sum_q <= '0;
        end
        CMD_ENV: begin
          env_arr_q[k] <= env_new;
          if (died) begin
            active_q[k] <= 1'b0;
          end
        end
        CMD_MUL2: begin
          mphase_q[k] <= mphase_q[k] + mstep_q[k];
          cphase_q[k] <= cphase_q[k] + cstep_q[k];
        end
        CMD_ACC: begin
          if (cneg_q) begin
            sum_q <= sum_q - $signed(SUM_W'(qv));
          end else begin
            sum_q <= sum_q + $signed(SUM_W'(qv));
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
